/* sv/dltq_pkg.sv */
// Shared types and constants for the delta list timer queue.
// No dependencies.
package dltq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int SLOT_W = 4;
    localparam int DELAY_W = 32;
    localparam int OWNER_W = 10;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  timer_slot;
        logic [DELAY_W-1:0] delay_ticks;
        logic [OWNER_W-1:0] owner_id;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  expired_slot;
        logic [OWNER_W-1:0] expired_owner;
        logic               last_expired;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DEL,
        ST_TICK,
        ST_EMIT
    } t_state;

endpackage

/* sv/dltq_front.sv */
// Front end: accepts items, drops ones that cannot do anything, queues the rest.
// Depends on dltq_pkg.
module dltq_front #(
    parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dltq_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output dltq_pkg::t_in_item  o_item
);
    import dltq_pkg::*;

    // Two-entry queue.
    t_in_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       keep, push, pop;

    always_comb begin
        keep = 1'b0;
        case (t_kind'(i_item.kind))
            KIND_ADD:  keep = (i_item.delay_ticks != '0) &&
                              (32'(i_item.timer_slot) < 32'(NUM_TIMERS));
            KIND_DEL:  keep = 32'(i_item.timer_slot) < 32'(NUM_TIMERS);
            KIND_TICK: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall && keep;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

/* sv/dltq_back.sv */
// Back end: linked list engine, one list step per cycle while the output is not stalled.
// Depends on dltq_pkg.
module dltq_back #(
    parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dltq_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output dltq_pkg::t_out_item o_item
);
    import dltq_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);

    logic [DELAY_W-1:0] r_delta [NUM_TIMERS];
    logic [OWNER_W-1:0] r_owner [NUM_TIMERS];
    logic [LW-1:0]      r_next [NUM_TIMERS];
    logic [LW-1:0]      r_prev [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_linked;
    logic [LW-1:0]      r_head;

    t_state             r_st, n_st;
    logic [IW-1:0]      r_slot;
    logic [DELAY_W-1:0] r_rem;
    logic [OWNER_W-1:0] r_own;
    logic [LW-1:0]      r_cur, r_prv;
    logic [LW:0]        r_guard;
    t_out_item          r_out;
    logic               r_ov;

    logic [IW-1:0] in_slot, cur_i, head_i;
    logic          out_free;
    logic          emit;
    logic [DELAY_W-1:0] cur_d;

    assign in_slot  = IW'(i_item.timer_slot);
    assign cur_i    = r_cur[IW-1:0];
    assign head_i   = r_head[IW-1:0];
    assign cur_d    = r_delta[cur_i];
    assign out_free = !r_ov || !i_stall;
    assign emit     = (r_st == ST_EMIT) && (n_st != ST_IDLE) && out_free;
    assign o_valid  = r_ov;
    assign o_item   = r_out;
    assign o_stall  = (r_st != ST_IDLE);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    case (t_kind'(i_item.kind))
                        KIND_ADD:  n_st = r_linked[in_slot] ? ST_IDLE : ST_WALK;
                        KIND_DEL:  n_st = r_linked[in_slot] ? ST_DEL : ST_IDLE;
                        KIND_TICK: n_st = (r_head == NIL) ? ST_IDLE : ST_TICK;
                        default:   n_st = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (r_cur == NIL || r_guard == (LW+1)'(NUM_TIMERS) || r_rem < cur_d)
                    n_st = ST_IDLE;
            end
            ST_DEL:  n_st = ST_IDLE;
            ST_TICK: n_st = ST_EMIT;
            ST_EMIT: begin
                if (r_head == NIL || r_delta[head_i] != '0)
                    n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_linked <= '0;
            r_head   <= NIL;
            r_ov     <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_next[i] <= NIL;
                r_prev[i] <= NIL;
            end
        end else begin
            if (emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    r_slot  <= in_slot;
                    r_rem   <= i_item.delay_ticks;
                    r_own   <= i_item.owner_id;
                    r_cur   <= r_head;
                    r_prv   <= NIL;
                    r_guard <= '0;
                    r_st    <= n_st;
                end
                ST_WALK: begin
                    if (n_st == ST_IDLE) begin
                        // Insert before r_cur.
                        if (r_cur != NIL && r_guard != (LW+1)'(NUM_TIMERS)
                                && r_rem < cur_d) begin
                            r_delta[cur_i] <= cur_d - r_rem;
                        end
                        r_delta[r_slot]  <= r_rem;
                        r_owner[r_slot]  <= r_own;
                        r_prev[r_slot]   <= r_prv;
                        r_next[r_slot]   <= r_cur;
                        r_linked[r_slot] <= 1'b1;
                        if (r_prv != NIL) r_next[r_prv[IW-1:0]] <= LW'(r_slot);
                        else              r_head <= LW'(r_slot);
                        if (r_cur != NIL) r_prev[cur_i] <= LW'(r_slot);
                    end else begin
                        r_rem   <= r_rem - cur_d;
                        r_prv   <= r_cur;
                        r_cur   <= r_next[cur_i];
                        r_guard <= r_guard + 1'b1;
                    end
                    r_st <= n_st;
                end
                ST_DEL: begin
                    if (r_next[r_slot] != NIL)
                        r_delta[r_next[r_slot][IW-1:0]] <=
                            r_delta[r_next[r_slot][IW-1:0]] + r_delta[r_slot];
                    if (r_prev[r_slot] != NIL)
                        r_next[r_prev[r_slot][IW-1:0]] <= r_next[r_slot];
                    else
                        r_head <= r_next[r_slot];
                    if (r_next[r_slot] != NIL)
                        r_prev[r_next[r_slot][IW-1:0]] <= r_prev[r_slot];
                    r_next[r_slot]   <= NIL;
                    r_prev[r_slot]   <= NIL;
                    r_linked[r_slot] <= 1'b0;
                    r_st <= n_st;
                end
                ST_TICK: begin
                    if (r_delta[head_i] != '0) r_delta[head_i] <= r_delta[head_i] - 1'b1;
                    r_st <= n_st;
                end
                ST_EMIT: begin
                    if (n_st == ST_IDLE) begin
                        r_st <= ST_IDLE;
                    end else if (out_free) begin
                        // Pop head; last if successor is not already at zero.
                        r_out.expired_slot  <= SLOT_W'(head_i);
                        r_out.expired_owner <= r_owner[head_i];
                        r_out.last_expired  <= (r_next[head_i] == NIL) ||
                            (r_delta[r_next[head_i][IW-1:0]] != '0);
                        r_head <= r_next[head_i];
                        if (r_next[head_i] != NIL)
                            r_prev[r_next[head_i][IW-1:0]] <= NIL;
                        r_next[head_i]   <= NIL;
                        r_prev[head_i]   <= NIL;
                        r_linked[head_i] <= 1'b0;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

/* sv/delta_list_timer_queue.sv */
// Top level of the delta list timer queue: front end, queue and list engine.
// Depends on dltq_pkg, dltq_front and dltq_back.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | i_in  (t_in_item)
//  out     | output    | o_valid / i_stall  | o_out (t_out_item)
//
// In the list engine an add walks the list in ST_WALK, past at most NUM_TIMERS
// entries; the front queue registers each item before the engine sees it.
// A delete runs in ST_DEL; a tick runs ST_TICK, then pops each expiry in ST_EMIT.
// The list engine handles one item at a time; a two-item queue sits in front.
// A stalled output holds the engine on the next expiry.
// Reset is synchronous and empties the list at once.
module delta_list_timer_queue #(
    parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dltq_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output dltq_pkg::t_out_item o_out
);
    import dltq_pkg::*;

    logic     q_valid, q_stall;
    t_in_item q_item;

    dltq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(i_in),
        .o_valid(q_valid), .i_stall(q_stall), .o_item(q_item)
    );

    dltq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_item(q_item),
        .o_valid, .i_stall, .o_item(o_out)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output changed while stalled");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_queue_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_stall |=> q_valid)
        else $error("queued item lost");
endmodule
